@@ sv/balanced_nearest_centroid_assign_assert.svh @@
// Assertion macros for the balanced nearest-centroid assignment block.
// Used by the top level only; no other dependencies.
`ifndef BALANCED_NEAREST_CENTROID_ASSIGN_ASSERT_SVH
`define BALANCED_NEAREST_CENTROID_ASSIGN_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BNCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define BNCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/bnca_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the balanced nearest-centroid assignment block.
// No dependencies.
package bnca_pkg;
    localparam int MAX_CLUSTERS_D = 16;
    localparam int MAX_DIMS_D     = 128;
    localparam int COORD_BITS_D   = 16;

    localparam int ACC_W  = 39;
    localparam int CNT_W  = 16;
    localparam int TYPE_W = 2;
    localparam int CI_W   = 4;
    localparam int DI_W   = 7;
    localparam int ACT_W  = 5;

    localparam logic [TYPE_W-1:0] REQ_CENTROID = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_COUNT    = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_POINT    = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_UNUSED   = 2'd3;

    localparam logic [1:0] CFG_ACTIVE   = 2'd0;
    localparam logic [1:0] CFG_CAPACITY = 2'd1;
    localparam logic [1:0] CFG_ID_BASE  = 2'd2;

    localparam logic [ACT_W-1:0] ACTIVE_RST = 5'd2;
    localparam logic [CNT_W-1:0] CAP_RST    = 16'hFFFF;

    // One queued request.
    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [CI_W-1:0]   ci;
        logic [DI_W-1:0]   di;
        logic [15:0]       coord;
        logic [CNT_W-1:0]  cnt;
        logic              last;
    } t_req;
endpackage

@@ sv/bnca_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts requests and holds them in a short queue for the back end.
// Depends on bnca_pkg.
module bnca_front import bnca_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_req o_req
);
    localparam int AW = $clog2(DEPTH);
    t_req r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_req   = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_req;
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

@@ sv/bnca_back.sv @@
`timescale 1ns / 1ps
// Back end: centroid memory, shared multiply-accumulate sweep and the choice scan.
// Depends on bnca_pkg.
module bnca_back import bnca_pkg::*; #(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_D,
    parameter int MAX_DIMS     = MAX_DIMS_D,
    parameter int COORD_BITS   = COORD_BITS_D
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_req              i_req,
    output logic              o_pop,
    input  logic [ACT_W-1:0]  i_active,
    input  logic [CNT_W-1:0]  i_capacity,
    input  logic [15:0]       i_id_base,
    output logic              o_strobe,
    output logic [15:0]       o_cluster_id,
    output logic              o_none_free,
    output logic [ACC_W-1:0]  o_best_distance,
    output logic              o_busy
);
    localparam int CW = $clog2(MAX_CLUSTERS);
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int MW = (MAX_CLUSTERS * MAX_DIMS > 1) ? $clog2(MAX_CLUSTERS * MAX_DIMS) : 1;
    localparam int SQ = 2 * (COORD_BITS + 1);
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MAC  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]              r_st;
    logic [CW:0]             r_c;
    logic [COORD_BITS-1:0]   mem [MAX_CLUSTERS*MAX_DIMS];
    logic [COORD_BITS-1:0]   r_rd;
    logic [CNT_W-1:0]        r_counts [MAX_CLUSTERS];
    logic [ACC_W-1:0]        r_acc [MAX_CLUSTERS];
    logic signed [COORD_BITS-1:0] r_p;
    logic [DW-1:0]           r_di;
    logic                    r_last;
    logic [SQ-1:0]           r_sq;
    logic [CW-1:0]           r_sqc;
    logic                    r_sqv;
    logic                    r_found;
    logic [CW-1:0]           r_best;
    logic [ACC_W-1:0]        r_bd;

    wire logic di_ok = ({25'd0, i_req.di} < 32'(MAX_DIMS));
    wire logic ci_ok = ({28'd0, i_req.ci} < 32'(MAX_CLUSTERS));
    logic [ACT_W:0] n_act;
    assign n_act = ({1'b0, i_active} > (ACT_W+1)'(MAX_CLUSTERS)) ?
                   (ACT_W+1)'(MAX_CLUSTERS) : {1'b0, i_active};

    assign o_pop  = (r_st == S_IDLE) && !i_empty;
    assign o_busy = (r_st != S_IDLE) || !i_empty;

    // squared difference, computed for one cluster at a time
    logic signed [COORD_BITS:0] diff;
    assign diff = $signed({r_rd[COORD_BITS-1], r_rd}) - $signed({r_p[COORD_BITS-1], r_p});
    logic signed [SQ-1:0] sq_full;
    assign sq_full = SQ'(diff) * SQ'(diff);
    logic [ACC_W:0] acc_sum;
    assign acc_sum = {1'b0, r_acc[r_sqc]} + (ACC_W+1)'(r_sq);

    wire logic [MW-1:0] raddr = MW'((MW)'(r_c[CW-1:0]) * MW'(MAX_DIMS) + MW'(r_di));

    // centroid memory
    always_ff @(posedge i_clk) begin
        if (o_pop && i_req.req_type == REQ_CENTROID && ci_ok && di_ok)
            mem[MW'(32'(i_req.ci) * MAX_DIMS + 32'(i_req.di))] <= i_req.coord[COORD_BITS-1:0];
        r_rd <= mem[raddr];
    end

    wire logic [CW-1:0] cidx = r_c[CW-1:0];
    wire logic cand = (r_c < (CW+1)'(n_act)) && (r_counts[cidx] < i_capacity);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_c <= '0; r_sqv <= 1'b0; o_strobe <= 1'b0;
            for (int k = 0; k < MAX_CLUSTERS; k++) begin
                r_counts[k] <= '0; r_acc[k] <= '0;
            end
        end else begin
            o_strobe <= 1'b0;
            // pipelined accumulate
            if (r_sqv) r_acc[r_sqc] <= acc_sum[ACC_W] ? ACC_MAX :
                                       (acc_sum[ACC_W-1:0]);
            r_sqv <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_req.req_type == REQ_COUNT && ci_ok)
                            r_counts[i_req.ci[CW-1:0]] <= i_req.cnt;
                        if (i_req.req_type == REQ_POINT) begin
                            r_p <= $signed(i_req.coord[COORD_BITS-1:0]);
                            r_di <= i_req.di[DW-1:0];
                            r_last <= i_req.last;
                            r_c <= '0;
                            r_st <= di_ok ? S_RD : (i_req.last ? S_SCAN : S_IDLE);
                            r_found <= 1'b0;
                        end
                    end
                end
                S_RD: begin
                    // memory read issued at r_c
                    r_st <= S_MAC;
                end
                S_MAC: begin
                    r_sq  <= $unsigned(sq_full);
                    r_sqc <= cidx;
                    r_sqv <= 1'b1;
                    if (r_c == (CW+1)'(MAX_CLUSTERS-1)) begin
                        r_c <= '0; r_found <= 1'b0;
                        r_st <= r_last ? S_SCAN : S_IDLE;
                    end else begin
                        r_c <= r_c + 1'b1; r_st <= S_RD;
                    end
                end
                S_SCAN: begin
                    if (!r_sqv) begin
                        if (cand && (!r_found || r_acc[cidx] < r_bd)) begin
                            r_found <= 1'b1; r_best <= cidx; r_bd <= r_acc[cidx];
                        end
                        if (r_c == (CW+1)'(MAX_CLUSTERS-1)) r_st <= S_OUT;
                        else r_c <= r_c + 1'b1;
                    end
                end
                S_OUT: begin
                    o_strobe <= 1'b1;
                    o_none_free <= !r_found;
                    o_cluster_id <= r_found ? i_id_base + 16'(r_best) : 16'd0;
                    o_best_distance <= r_found ? r_bd : '0;
                    if (r_found) r_counts[r_best] <= r_counts[r_best] + 1'b1;
                    for (int k = 0; k < MAX_CLUSTERS; k++) r_acc[k] <= '0;
                    r_c <= '0;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/balanced_nearest_centroid_assign.sv @@
`timescale 1ns / 1ps
// Top level of the balanced nearest-centroid assignment block.
// Depends on bnca_pkg, bnca_front, bnca_back and the assertion header.
// A request is taken at a rising edge where start is high and busy is low;
// it enters a four-entry queue, and busy is high exactly while that queue is
// full. The back end takes one request from the queue per cycle while idle.
// A write or an unknown request leaves the back end idle. A point coordinate
// with an in-range dim leaves the queue, then each cluster in turn gets one
// memory read and one shared multiply step. The coordinate marked last then
// adds a step to settle the final sum, a scan over all MAX_CLUSTERS clusters
// and a result step. The result is then on the outputs, marked by o_done for
// one cycle; the receiver cannot stall it.
`include "balanced_nearest_centroid_assign_assert.svh"
module balanced_nearest_centroid_assign import bnca_pkg::*; #(
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_D,
    parameter int MAX_DIMS     = MAX_DIMS_D,
    parameter int COORD_BITS   = COORD_BITS_D
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    input  logic [TYPE_W-1:0]      i_req_type,
    input  logic [CI_W-1:0]        i_cluster_index,
    input  logic [DI_W-1:0]        i_dim_index,
    input  logic signed [15:0]     i_coord_value,
    input  logic [CNT_W-1:0]       i_count_value,
    input  logic                   i_is_last,
    output logic                   o_done,
    output logic [15:0]            o_cluster_id,
    output logic                   o_none_free,
    output logic [ACC_W-1:0]       o_best_distance
);
    logic [ACT_W-1:0] r_active;
    logic [CNT_W-1:0] r_capacity;
    logic [15:0]      r_id_base;
    logic full, empty, pop, bbusy;
    t_req req_in, req_q;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RST; r_capacity <= CAP_RST; r_id_base <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE:   r_active   <= i_cfg_data[ACT_W-1:0];
                CFG_CAPACITY: r_capacity <= i_cfg_data;
                CFG_ID_BASE:  r_id_base  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = full;
    assign req_in = '{req_type: i_req_type, ci: i_cluster_index, di: i_dim_index,
                      coord: i_coord_value, cnt: i_count_value, last: i_is_last};

    bnca_front #(.DEPTH(4)) u_front (
        .i_clk, .i_rst_n, .i_push(start && !full), .i_req(req_in),
        .i_pop(pop), .o_full(full), .o_empty(empty), .o_req(req_q)
    );

    bnca_back #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_DIMS(MAX_DIMS),
                .COORD_BITS(COORD_BITS)) u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_req(req_q), .o_pop(pop),
        .i_active(r_active), .i_capacity(r_capacity), .i_id_base(r_id_base),
        .o_strobe(o_done), .o_cluster_id, .o_none_free, .o_best_distance,
        .o_busy(bbusy)
    );

    `BNCA_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, pop, !empty)
    `BNCA_ASSERT_IMP(a_none_zero, i_clk, i_rst_n, o_done && o_none_free, o_best_distance == '0)
    `BNCA_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done)
    `BNCA_ASSERT_IMP(a_full_busy, i_clk, i_rst_n, full, bbusy)
endmodule

@@ dv/balanced_nearest_centroid_assign_checker.sv @@
`timescale 1ns / 1ps
// Checker for the balanced nearest-centroid assignment block: mirrors the
// centroid table, fill counts and distance sums, and compares every result.
// Depends on bnca_pkg.
module balanced_nearest_centroid_assign_checker import bnca_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic [TYPE_W-1:0]  i_req_type,
    input  logic [CI_W-1:0]    i_cluster_index,
    input  logic [DI_W-1:0]    i_dim_index,
    input  logic signed [15:0] i_coord_value,
    input  logic [CNT_W-1:0]   i_count_value,
    input  logic               i_is_last,
    input  logic               i_done,
    input  logic [15:0]        i_cluster_id,
    input  logic               i_none_free,
    input  logic [ACC_W-1:0]   i_best_distance,
    output int                 o_fail_count,
    output int                 o_pending
);
    localparam logic [ACC_W-1:0] DIST_SAT = {ACC_W{1'b1}};

    typedef struct {
        logic [15:0]      chosen_id;
        logic             none_free;
        logic [ACC_W-1:0] distance;
    } assign_t;

    logic signed [15:0] centroid_tab [MAX_CLUSTERS_D][MAX_DIMS_D];
    logic [CNT_W-1:0]   fill_cnt [MAX_CLUSTERS_D];
    logic [ACC_W-1:0]   dist_sum [MAX_CLUSTERS_D];
    logic [ACT_W-1:0]   n_active;
    logic [15:0]        cap;
    logic [15:0]        base_id;
    assign_t            expected_assigns[$];
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_assigns.size();

    // Model one accepted request; queue a result on a closing coordinate.
    task automatic predict_assign(input t_req r);
        logic signed [17:0] diff;
        logic [16:0]        mag;
        logic [39:0]        sum;
        int                 n;
        int                 best;
        bit                 found;
        assign_t            a;
        if (r.req_type == REQ_CENTROID) begin
            centroid_tab[r.ci][r.di] = r.coord;
        end else if (r.req_type == REQ_COUNT) begin
            fill_cnt[r.ci] = r.cnt;
        end else if (r.req_type == REQ_POINT) begin
            for (int c = 0; c < MAX_CLUSTERS_D; c++) begin
                diff = 18'(centroid_tab[c][r.di]) - 18'(signed'(r.coord));
                mag  = diff[17] ? 17'(-diff) : diff[16:0];
                sum  = {1'b0, dist_sum[c]} + (40'(mag) * 40'(mag));
                dist_sum[c] = sum[39] ? DIST_SAT : sum[ACC_W-1:0];
            end
            if (r.last) begin
                n = (n_active > MAX_CLUSTERS_D) ? MAX_CLUSTERS_D : n_active;
                found = 0;
                best = 0;
                for (int c = 0; c < n; c++) begin
                    if (fill_cnt[c] < cap && (!found || dist_sum[c] < dist_sum[best])) begin
                        found = 1;
                        best = c;
                    end
                end
                if (found) begin
                    fill_cnt[best]++;
                    a.chosen_id = base_id + 16'(best);
                    a.none_free = 0;
                    a.distance  = dist_sum[best];
                end else begin
                    a.chosen_id = '0;
                    a.none_free = 1;
                    a.distance  = '0;
                end
                expected_assigns = {expected_assigns, a};
                foreach (dist_sum[c]) dist_sum[c] = '0;
            end
        end
    endtask

    // Track configuration, requests and results on each edge.
    always @(posedge i_clk) begin
        t_req    r;
        assign_t e;
        if (!i_rst_n) begin
            foreach (fill_cnt[c]) fill_cnt[c] = '0;
            foreach (dist_sum[c]) dist_sum[c] = '0;
            n_active = ACTIVE_RST;
            cap      = CAP_RST;
            base_id  = '0;
            expected_assigns.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE:   n_active = i_cfg_data[ACT_W-1:0];
                    CFG_CAPACITY: cap = i_cfg_data;
                    CFG_ID_BASE:  base_id = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_done) begin
                if (expected_assigns.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: unexpected result id=%0d none=%0b dist=%0d",
                                 i_cluster_id, i_none_free, i_best_distance);
                end else begin
                    e = expected_assigns.pop_front();
                    if (i_cluster_id !== e.chosen_id || i_none_free !== e.none_free ||
                        i_best_distance !== e.distance) begin
                        fails++;
                        if (fails <= 10)
                            $display("ERROR: exp id=%0d none=%0b dist=%0d, got id=%0d none=%0b dist=%0d",
                                     e.chosen_id, e.none_free, e.distance,
                                     i_cluster_id, i_none_free, i_best_distance);
                    end
                end
            end
            if (i_start && !i_busy) begin
                r.req_type = i_req_type;
                r.ci       = i_cluster_index;
                r.di       = i_dim_index;
                r.coord    = i_coord_value;
                r.cnt      = i_count_value;
                r.last     = i_is_last;
                predict_assign(r);
            end
        end
    end

    initial fails = 0;
endmodule

@@ dv/balanced_nearest_centroid_assign_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the balanced nearest-centroid assignment block: drives
// table writes, count presets and point streams through several settings.
// Depends on bnca_pkg, the block and balanced_nearest_centroid_assign_checker.
module balanced_nearest_centroid_assign_test;
    import bnca_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 300;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic               i_cfg_we = 0;
    logic [1:0]         i_cfg_index = CFG_ACTIVE;
    logic [15:0]        i_cfg_data = '0;
    logic [TYPE_W-1:0]  i_req_type = REQ_COUNT;
    logic [CI_W-1:0]    i_cluster_index = '0;
    logic [DI_W-1:0]    i_dim_index = '0;
    logic signed [15:0] i_coord_value = '0;
    logic [CNT_W-1:0]   i_count_value = '0;
    logic               i_is_last = 0;
    logic               o_done;
    logic [15:0]        o_cluster_id;
    logic               o_none_free;
    logic [ACC_W-1:0]   o_best_distance;
    int                 fail_count;
    int                 pending;
    int                 cycles = 0;
    int                 burst_left = 0;
    logic [DI_W-1:0]    ready_dims[$];
    logic [15:0]        caps [7] = '{16'hFFFF, 16'd1, 16'd3, 16'd5, 16'd10, 16'd0, 16'd40};
    logic [15:0]        acts [7] = '{16'd2, 16'd1, 16'd16, 16'd0, 16'd31, 16'd17, 16'd5};
    logic [15:0]        bases [7] = '{16'd0, 16'hFFFF, 16'd100, 16'd7, 16'hFFF8, 16'd1,
                                      16'h8000};

    always #2 i_clk = ~i_clk;

    balanced_nearest_centroid_assign dut (.*);

    balanced_nearest_centroid_assign_checker checker_i (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cfg_we, .i_cfg_index,
        .i_cfg_data, .i_req_type, .i_cluster_index, .i_dim_index, .i_coord_value,
        .i_count_value, .i_is_last, .i_done(o_done), .i_cluster_id(o_cluster_id),
        .i_none_free(o_none_free), .i_best_distance(o_best_distance),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("balanced_nearest_centroid_assign verification failed");
            $finish;
        end
    end

    // Issue one request, with bursts and random gaps before it.
    task automatic send(input logic [TYPE_W-1:0] t, input logic [CI_W-1:0] ci,
                        input logic [DI_W-1:0] di, input logic [15:0] cv,
                        input logic [CNT_W-1:0] cnt, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                start <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1;
        i_req_type <= t;
        i_cluster_index <= ci;
        i_dim_index <= di;
        i_coord_value <= cv;
        i_count_value <= cnt;
        i_is_last <= last;
        forever begin
            @(negedge i_clk);
            if (!busy) begin
                @(posedge i_clk);
                break;
            end
        end
    endtask

    // Stop sending and let every outstanding request finish.
    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write enable is left high; the caller drops it after the last write.
    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Stream one point over dims whose centroids are all written.
    task automatic send_point(input int len);
        for (int k = 0; k < len; k++)
            send(REQ_POINT, 4'($urandom), ready_dims[$urandom_range(0, ready_dims.size() - 1)],
                 pick_coord(), 16'($urandom), k == len - 1);
    endtask

    task automatic random_phase(input int items, input logic [15:0] cap);
        int n;
        int kind;
        n = 0;
        while (n < items) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                n += 1;
                send_point(($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                       : $urandom_range(1, 4));
            end else if (kind < 87) begin
                send(REQ_CENTROID, 4'($urandom),
                     ready_dims[$urandom_range(0, ready_dims.size() - 1)],
                     pick_coord(), 16'($urandom), 1'($urandom));
            end else if (kind < 96) begin
                send(REQ_COUNT, 4'($urandom), 7'($urandom), 16'($urandom),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom)
                         : 16'($urandom_range(0, 32'(cap) + 1)), 1'($urandom));
            end else begin
                send(REQ_UNUSED, 4'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom));
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Fill the table at the low and high dims for every cluster.
        for (int d = 0; d < 8; d++) begin
            ready_dims = {ready_dims, (d < 4) ? 7'(d) : 7'(120 + d)};
            for (int c = 0; c < MAX_CLUSTERS_D; c++)
                send(REQ_CENTROID, 4'(c), ready_dims[d], pick_coord(), '0, 1'(c & 1));
        end

        // Directed: extremes, ignored type, last mark on writes, preset counts.
        send(REQ_POINT, 4'd15, 7'd127, 16'h7FFF, 16'hFFFF, 1);
        send(REQ_POINT, 4'd0, 7'd0, 16'h8000, 16'h0000, 1);
        send(REQ_UNUSED, 4'd15, 7'd127, 16'hFFFF, 16'hFFFF, 1);
        send(REQ_COUNT, 4'd0, 7'd0, 16'h0, 16'hFFFF, 1);
        send(REQ_POINT, 4'd0, 7'd3, 16'h1234, 16'h0, 1);
        send(REQ_COUNT, 4'd0, 7'd0, 16'h0, 16'h0, 0);
        send(REQ_COUNT, 4'd1, 7'd127, 16'h0, 16'hFFFE, 1);
        send(REQ_POINT, 4'd0, 7'd124, 16'h0, 16'h0, 1);
        send(REQ_POINT, 4'd0, 7'd125, 16'h0, 16'h0, 1);
        // Long point to drive the distance sums into saturation.
        for (int c = 0; c < MAX_CLUSTERS_D; c++)
            for (int d = 0; d < 4; d++)
                send(REQ_CENTROID, 4'(c), 7'(d), 16'h8000, '0, 0);
        for (int k = 0; k < 140; k++)
            send(REQ_POINT, 4'd0, 7'(k % 4), 16'h7FFF, '0, k == 139);
        send(REQ_POINT, 4'd0, 7'd0, 16'h7FFF, '0, 1);

        // Random phases through several settings.
        for (int p = 0; p < 7; p++) begin
            drain();
            cfg_write(CFG_ACTIVE, acts[p]);
            cfg_write(CFG_CAPACITY, caps[p]);
            cfg_write(CFG_ID_BASE, bases[p]);
            i_cfg_we <= 0;
            for (int c = 0; c < MAX_CLUSTERS_D; c++)
                send(REQ_COUNT, 4'(c), '0, '0, '0, 0);
            random_phase(9, caps[p]);
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("balanced_nearest_centroid_assign verification clean");
        else
            $display("balanced_nearest_centroid_assign verification failed");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/bnca_pkg.sv
sv/bnca_front.sv
sv/bnca_back.sv
sv/balanced_nearest_centroid_assign.sv
dv/balanced_nearest_centroid_assign_checker.sv
dv/balanced_nearest_centroid_assign_test.sv
